// ===== src/grdm_pkg.sv =====
package grdm_pkg;

    localparam int NUM_MARKS = 5;
    localparam int MARK_W    = 7;
    localparam int NUM_RULER = NUM_MARKS + 1;
    localparam int NUM_DIFFS = NUM_RULER * (NUM_RULER - 1) / 2;
    localparam int HALF_BITS = 64;
    localparam int MASK_W    = 2 * HALF_BITS;
    localparam int RANK_W    = $clog2(NUM_MARKS);

    typedef logic [MARK_W-1:0]           t_mark;
    typedef logic [HALF_BITS-1:0]        t_half;
    typedef logic [MASK_W-1:0]           t_mask;
    typedef logic [RANK_W-1:0]           t_rank;
    typedef t_mark [NUM_MARKS-1:0]       t_marks;
    typedef t_rank [NUM_MARKS-1:0]       t_ranks;
    typedef t_mark [NUM_RULER-1:0]       t_ruler;
    typedef t_mark [NUM_DIFFS-1:0]       t_diffs;

    localparam t_mark MAX_DIFF_RESET = 7'd111;

endpackage

// ===== src/grdm_ifs.sv =====
interface grdm_mark_if;
    import grdm_pkg::*;

    logic  valid;
    logic  ready;
    t_mark first_mark;
    t_mark second_mark;
    t_mark third_mark;
    t_mark fourth_mark;
    t_mark fifth_mark;

    modport source (
        output valid, first_mark, second_mark, third_mark, fourth_mark, fifth_mark,
        input  ready
    );
    modport sink (
        input  valid, first_mark, second_mark, third_mark, fourth_mark, fifth_mark,
        output ready
    );
endinterface

interface grdm_result_if;
    import grdm_pkg::*;

    logic  valid;
    logic  ready;
    logic  ruler_valid;
    t_half mask_low;
    t_half mask_high;
    t_mark sorted_first;
    t_mark sorted_second;
    t_mark sorted_third;
    t_mark sorted_fourth;
    t_mark sorted_fifth;

    modport source (
        output valid, ruler_valid, mask_low, mask_high,
               sorted_first, sorted_second, sorted_third, sorted_fourth, sorted_fifth,
        input  ready
    );
    modport sink (
        input  valid, ruler_valid, mask_low, mask_high,
               sorted_first, sorted_second, sorted_third, sorted_fourth, sorted_fifth,
        output ready
    );
endinterface

// ===== src/golomb_ruler_difference_mask.sv =====
// Channel      Dir  Handshake     Word
// i_mark       in   valid/ready   five 7-bit candidate marks
// o_result     out  valid/ready   valid flag, 128-bit mask, sorted marks
// i_cfg_*      in   write enable  max_difference (7 bits)
//
// Four register stages: rank, sort, differences, mask/check.
// One word per cycle while o_result is not stalled.
// A stall holds every occupied stage; empty stages still fill (bubbles collapse).
// Synchronous active-low reset clears stage valids and sets max_difference to 111.
module golomb_ruler_difference_mask (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  grdm_pkg::t_mark i_cfg_wdata,
    grdm_mark_if.sink       i_mark,
    grdm_result_if.source   o_result
);
    import grdm_pkg::*;

    t_mark  r_max_difference;

    logic   r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic   load1, load2, load3, load4;

    t_marks in_marks;
    t_ranks n_ranks;
    t_marks r_s1_marks;
    t_ranks r_s1_ranks;

    t_marks n_sorted;
    t_marks r_s2_sorted;

    t_ruler ruler;
    t_diffs n_diffs;
    logic   n_range_ok;
    t_diffs r_s3_diffs;
    logic   r_s3_range_ok;
    t_marks r_s3_sorted;

    t_mask  n_mask;
    logic   n_dup;
    logic   n_ok;
    t_mask  r_out_mask;
    logic   r_out_ok;
    t_marks r_out_sorted;

    assign load4 = !r_out_valid || o_result.ready;
    assign load3 = !r_s3_valid || load4;
    assign load2 = !r_s2_valid || load3;
    assign load1 = !r_s1_valid || load2;

    assign i_mark.ready = load1;

    assign in_marks[0] = i_mark.first_mark;
    assign in_marks[1] = i_mark.second_mark;
    assign in_marks[2] = i_mark.third_mark;
    assign in_marks[3] = i_mark.fourth_mark;
    assign in_marks[4] = i_mark.fifth_mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_difference <= MAX_DIFF_RESET;
            r_s1_valid       <= 1'b0;
            r_s2_valid       <= 1'b0;
            r_s3_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_difference <= i_cfg_wdata;
            end
            if (load1) begin
                r_s1_valid <= i_mark.valid;
            end
            if (load2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (load3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (load4) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    // stable rank: ties go to the lower input index
    always_comb begin
        for (int i = 0; i < NUM_MARKS; i++) begin
            n_ranks[i] = '0;
            for (int j = 0; j < NUM_MARKS; j++) begin
                if ((j < i && in_marks[j] <= in_marks[i]) ||
                    (j > i && in_marks[j] <  in_marks[i])) begin
                    n_ranks[i] = n_ranks[i] + RANK_W'(1);
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_MARKS; k++) begin
            n_sorted[k] = '0;
            for (int i = 0; i < NUM_MARKS; i++) begin
                if (r_s1_ranks[i] == RANK_W'(k)) begin
                    n_sorted[k] = r_s1_marks[i];
                end
            end
        end
    end

    always_comb begin
        int p;
        p          = 0;
        n_range_ok = 1'b1;
        ruler[0]   = '0;
        for (int k = 0; k < NUM_MARKS; k++) begin
            ruler[k+1] = r_s2_sorted[k];
        end
        for (int a = 0; a < NUM_RULER; a++) begin
            for (int b = a + 1; b < NUM_RULER; b++) begin
                n_diffs[p] = ruler[b] - ruler[a];
                if (n_diffs[p] == '0 || n_diffs[p] > r_max_difference) begin
                    n_range_ok = 1'b0;
                end
                p = p + 1;
            end
        end
    end

    always_comb begin
        n_mask = '0;
        n_dup  = 1'b0;
        for (int p = 0; p < NUM_DIFFS; p++) begin
            n_mask[r_s3_diffs[p]] = 1'b1;
            for (int q = p + 1; q < NUM_DIFFS; q++) begin
                if (r_s3_diffs[p] == r_s3_diffs[q]) begin
                    n_dup = 1'b1;
                end
            end
        end
        n_ok = r_s3_range_ok && !n_dup;
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_s1_marks <= in_marks;
            r_s1_ranks <= n_ranks;
        end
        if (load2) begin
            r_s2_sorted <= n_sorted;
        end
        if (load3) begin
            r_s3_diffs    <= n_diffs;
            r_s3_range_ok <= n_range_ok;
            r_s3_sorted   <= r_s2_sorted;
        end
        if (load4) begin
            r_out_ok     <= n_ok;
            r_out_mask   <= n_ok ? n_mask : '0;
            r_out_sorted <= r_s3_sorted;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.ruler_valid   = r_out_ok;
    assign o_result.mask_low      = r_out_mask[HALF_BITS-1:0];
    assign o_result.mask_high     = r_out_mask[MASK_W-1:HALF_BITS];
    assign o_result.sorted_first  = r_out_sorted[0];
    assign o_result.sorted_second = r_out_sorted[1];
    assign o_result.sorted_third  = r_out_sorted[2];
    assign o_result.sorted_fourth = r_out_sorted[3];
    assign o_result.sorted_fifth  = r_out_sorted[4];

endmodule
